/* rtl/core/axis_angle_to_rotation_matrix_top_assert.svh */
// assertion macros shared by the rotation matrix rtl
// relies on clk and arst_n being visible where a macro is used
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_TOP_ASSERT_SVH

// property that must hold in the same cycle
`define AAR_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define AAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/aar_pkg.sv */
// shared types, constants and the arctangent table of the rotation matrix pipeline
// used by every cell module and the top level
package aar_pkg;

	localparam int SQRT_CELLS    = 16;
	localparam int UDIV_CELLS    = 15;
	localparam int RATIO_CELLS   = 15;
	localparam int CORDIC_STAGES = 16;

	localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
	localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
	localparam logic signed [31:0] Q28_TWO_PI  = 32'sd1686629713;
	localparam logic signed [31:0] Q28_GAIN    = 32'sd163008218;
	localparam logic [15:0]        ONE_Q14     = 16'd16384;

	// square root digit cell payload
	typedef struct packed {
		logic             vld;
		logic [31:0]      rem;
		logic [32:0]      root;
		logic [2:0][15:0] v;
	} sqrt_bus_t;

	// axis division cell payload, three lanes
	typedef struct packed {
		logic             vld;
		logic [15:0]      a;
		logic [2:0][29:0] rem;
		logic [2:0][14:0] quo;
		logic [2:0]       neg;
	} udiv_bus_t;

	// rotation cell payload
	typedef struct packed {
		logic             vld;
		logic             zero;
		logic             flip;
		logic [31:0]      x;
		logic [31:0]      y;
		logic [31:0]      z;
		logic [2:0][15:0] u;
	} cordic_bus_t;

	// matrix entry division cell payload, nine lanes
	typedef struct packed {
		logic             vld;
		logic             ident;
		logic [46:0]      n;
		logic [8:0][62:0] rem;
		logic [8:0][14:0] quo;
		logic [8:0]       neg;
	} ratio_bus_t;

	// atan(2^-i) in Q28, rounded to nearest
	function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
		logic signed [31:0] r;
		case (idx)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			5'd24: r = 32'sd16;
			5'd25: r = 32'sd8;
			5'd26: r = 32'sd4;
			5'd27: r = 32'sd2;
			5'd28: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/aar_sqrt_cell.sv */
// one digit of the integer square root, one result bit per cell
// depends on aar_pkg
module aar_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [3:0]        step,
	input  aar_pkg::sqrt_bus_t d_in,
	output aar_pkg::sqrt_bus_t d_out
);
	import aar_pkg::*;

	logic [32:0] bitv;
	logic [32:0] trial;
	sqrt_bus_t   nxt;
	sqrt_bus_t   bus_q;
	logic        vld_q;

	// trial subtract of root plus the current bit
	always_comb begin
		bitv  = 33'(1) << (5'd30 - {step, 1'b0});
		trial = d_in.root + bitv;
		nxt   = d_in;
		if ({1'b0, d_in.rem} >= trial) begin
			nxt.rem  = d_in.rem - trial[31:0];
			nxt.root = (d_in.root >> 1) + bitv;
		end else begin
			nxt.root = d_in.root >> 1;
		end
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= nxt;
		end
	end

	always_comb begin
		d_out     = bus_q;
		d_out.vld = vld_q;
	end

endmodule

/* rtl/core/aar_udiv_cell.sv */
// one quotient bit of the three axis divisions, magnitude times 2^14 over the angle
// depends on aar_pkg
module aar_udiv_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [3:0]        bpos,
	input  aar_pkg::udiv_bus_t d_in,
	output aar_pkg::udiv_bus_t d_out
);
	import aar_pkg::*;

	logic [29:0] dshift;
	udiv_bus_t   nxt;
	udiv_bus_t   bus_q;
	logic        vld_q;

	// compare and subtract in each lane, quotient shifts in msb first
	always_comb begin
		dshift = {14'b0, d_in.a} << bpos;
		nxt    = d_in;
		for (int i = 0; i < 3; i++) begin
			if (d_in.rem[i] >= dshift) begin
				nxt.rem[i] = d_in.rem[i] - dshift;
				nxt.quo[i] = {d_in.quo[i][13:0], 1'b1};
			end else begin
				nxt.quo[i] = {d_in.quo[i][13:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= nxt;
		end
	end

	always_comb begin
		d_out     = bus_q;
		d_out.vld = vld_q;
	end

endmodule

/* rtl/core/aar_cordic_cell.sv */
// one rotation-mode cordic iteration on the half angle
// depends on aar_pkg
module aar_cordic_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [4:0]          idx,
	input  aar_pkg::cordic_bus_t d_in,
	output aar_pkg::cordic_bus_t d_out
);
	import aar_pkg::*;

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] at;
	cordic_bus_t        nxt;
	cordic_bus_t        bus_q;
	logic               vld_q;

	// micro-rotation toward zero residual angle
	always_comb begin
		dx  = $signed(d_in.y) >>> idx;
		dy  = $signed(d_in.x) >>> idx;
		at  = atan_q28(idx);
		nxt = d_in;
		if (!d_in.z[31]) begin
			nxt.x = 32'($signed(d_in.x) - dx);
			nxt.y = 32'($signed(d_in.y) + dy);
			nxt.z = 32'($signed(d_in.z) - at);
		end else begin
			nxt.x = 32'($signed(d_in.x) + dx);
			nxt.y = 32'($signed(d_in.y) - dy);
			nxt.z = 32'($signed(d_in.z) + at);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= nxt;
		end
	end

	always_comb begin
		d_out     = bus_q;
		d_out.vld = vld_q;
	end

endmodule

/* rtl/core/aar_ratio_cell.sv */
// one quotient bit of the nine matrix entry divisions by the quaternion norm
// depends on aar_pkg
module aar_ratio_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [3:0]         bpos,
	input  aar_pkg::ratio_bus_t d_in,
	output aar_pkg::ratio_bus_t d_out
);
	import aar_pkg::*;

	logic [62:0] dshift;
	ratio_bus_t  nxt;
	ratio_bus_t  bus_q;
	logic        vld_q;

	// compare and subtract in each lane
	always_comb begin
		dshift = {16'b0, d_in.n} << bpos;
		nxt    = d_in;
		for (int k = 0; k < 9; k++) begin
			if (d_in.rem[k] >= dshift) begin
				nxt.rem[k] = d_in.rem[k] - dshift;
				nxt.quo[k] = {d_in.quo[k][13:0], 1'b1};
			end else begin
				nxt.quo[k] = {d_in.quo[k][13:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_q <= nxt;
		end
	end

	always_comb begin
		d_out     = bus_q;
		d_out.vld = vld_q;
	end

endmodule

/* rtl/core/axis_angle_to_rotation_matrix_top.sv */
// axis-angle (q4.12) to row-major rotation matrix (q2.14), fully pipelined
// registered through the square root, axis division, cordic and entry division
// cell rows, one bit or iteration a cell
// throughput: one beat per cycle; the whole pipe holds while a result beat is stalled
// reset: arst_n clears every valid flag at once, payload registers are not reset
`include "axis_angle_to_rotation_matrix_top_assert.svh"

module axis_angle_to_rotation_matrix_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] r00,
	output logic signed [15:0] r01,
	output logic signed [15:0] r02,
	output logic signed [15:0] r10,
	output logic signed [15:0] r11,
	output logic signed [15:0] r12,
	output logic signed [15:0] r20,
	output logic signed [15:0] r21,
	output logic signed [15:0] r22
);
	import aar_pkg::*;

	logic en;

	logic               vld_s1;
	logic [2:0][15:0]   v_s1;
	logic [2:0][30:0]   sq_s1;
	logic               vld_s2;
	logic [2:0][15:0]   v_s2;
	logic [31:0]        sum_s2;

	sqrt_bus_t   sq_c [SQRT_CELLS+1];
	udiv_bus_t   ud_c [UDIV_CELLS+1];
	cordic_bus_t co_c [CORDIC_STAGES+1];
	ratio_bus_t  ra_c [RATIO_CELLS+1];

	cordic_bus_t cin_n;
	cordic_bus_t cin_s3;
	logic        cin_vld_s3;

	logic               vld_s4;
	logic               zero_s4;
	logic signed [23:0] w_s4;
	logic signed [47:0] p_s4 [3];

	logic               vld_s5;
	logic               zero_s5;
	logic signed [47:0] ww_s5, xx_s5, yy_s5, zz_s5;
	logic signed [47:0] wx_s5, wy_s5, wz_s5, xy_s5, xz_s5, yz_s5;

	logic               vld_s6;
	logic               zero_s6;
	logic signed [47:0] n_s6;
	logic signed [47:0] m_s6 [9];

	logic        out_vld_q;
	logic [15:0] r_q [9];
	logic [15:0] r_n [9];

	// global advance: the pipe moves unless a result beat is held
	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;

	// squares of the components
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1     <= {angle_z, angle_y, angle_x};
			sq_s1[0] <= 31'(angle_x * angle_x);
			sq_s1[1] <= 31'(angle_y * angle_y);
			sq_s1[2] <= 31'(angle_z * angle_z);
			v_s2     <= v_s1;
			sum_s2   <= 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
		end
	end

	// square root cell row
	always_comb begin
		sq_c[0].vld  = vld_s2;
		sq_c[0].rem  = sum_s2;
		sq_c[0].root = '0;
		sq_c[0].v    = v_s2;
	end

	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		aar_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.step  (4'(j)),
			.d_in  (sq_c[j]),
			.d_out (sq_c[j+1])
		);
	end

	// axis division setup from magnitudes
	always_comb begin
		ud_c[0].vld = sq_c[SQRT_CELLS].vld;
		ud_c[0].a   = sq_c[SQRT_CELLS].root[15:0];
		for (int i = 0; i < 3; i++) begin
			ud_c[0].neg[i] = sq_c[SQRT_CELLS].v[i][15];
			ud_c[0].rem[i] = sq_c[SQRT_CELLS].v[i][15] ?
				{16'(16'd0 - sq_c[SQRT_CELLS].v[i]), 14'b0} :
				{sq_c[SQRT_CELLS].v[i], 14'b0};
			ud_c[0].quo[i] = '0;
		end
	end

	for (genvar j = 0; j < UDIV_CELLS; j++) begin : g_udiv
		aar_udiv_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.bpos  (4'(UDIV_CELLS - 1 - j)),
			.d_in  (ud_c[j]),
			.d_out (ud_c[j+1])
		);
	end

	// half angle range reduction and signed axis
	always_comb begin
		logic signed [31:0] h;
		h           = $signed({1'b0, ud_c[UDIV_CELLS].a, 15'b0});
		cin_n       = '0;
		cin_n.vld   = ud_c[UDIV_CELLS].vld;
		cin_n.zero  = (ud_c[UDIV_CELLS].a == 16'd0);
		cin_n.flip  = 1'b0;
		if (h > Q28_PI) begin
			h = h - Q28_TWO_PI;
		end
		if (h > Q28_HALF_PI) begin
			h          = h - Q28_PI;
			cin_n.flip = 1'b1;
		end else if (h < -Q28_HALF_PI) begin
			h          = h + Q28_PI;
			cin_n.flip = 1'b1;
		end
		cin_n.x = Q28_GAIN;
		cin_n.y = '0;
		cin_n.z = h;
		for (int i = 0; i < 3; i++) begin
			cin_n.u[i] = ud_c[UDIV_CELLS].neg[i] ?
				16'(16'd0 - {1'b0, ud_c[UDIV_CELLS].quo[i]}) :
				{1'b0, ud_c[UDIV_CELLS].quo[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cin_vld_s3 <= 1'b0;
		end else if (en) begin
			cin_vld_s3 <= cin_n.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cin_s3 <= cin_n;
		end
	end

	always_comb begin
		co_c[0]     = cin_s3;
		co_c[0].vld = cin_vld_s3;
	end

	// cordic cell row
	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
		aar_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.idx   (5'(j)),
			.d_in  (co_c[j]),
			.d_out (co_c[j+1])
		);
	end

	// quaternion: w from cosine, vector part from sine times axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= co_c[CORDIC_STAGES].vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [23:0] qx, qy, qz;
		if (en) begin
			cx = co_c[CORDIC_STAGES].flip ? 32'(-$signed(co_c[CORDIC_STAGES].x)) :
				$signed(co_c[CORDIC_STAGES].x);
			cy = co_c[CORDIC_STAGES].flip ? 32'(-$signed(co_c[CORDIC_STAGES].y)) :
				$signed(co_c[CORDIC_STAGES].y);
			zero_s4 <= co_c[CORDIC_STAGES].zero;
			w_s4    <= 24'(cx >>> 8);
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= cy * $signed(co_c[CORDIC_STAGES].u[i]);
			end

			// pairwise products
			qx      = 24'(p_s4[0] >>> 22);
			qy      = 24'(p_s4[1] >>> 22);
			qz      = 24'(p_s4[2] >>> 22);
			zero_s5 <= zero_s4;
			ww_s5   <= w_s4 * w_s4;
			xx_s5   <= qx * qx;
			yy_s5   <= qy * qy;
			zz_s5   <= qz * qz;
			wx_s5   <= w_s4 * qx;
			wy_s5   <= w_s4 * qy;
			wz_s5   <= w_s4 * qz;
			xy_s5   <= qx * qy;
			xz_s5   <= qx * qz;
			yz_s5   <= qy * qz;

			// norm and entry numerators
			zero_s6 <= zero_s5;
			n_s6    <= ww_s5 + xx_s5 + yy_s5 + zz_s5;
			m_s6[0] <= ww_s5 + xx_s5 - yy_s5 - zz_s5;
			m_s6[1] <= (xy_s5 - wz_s5) <<< 1;
			m_s6[2] <= (wy_s5 + xz_s5) <<< 1;
			m_s6[3] <= (wz_s5 + xy_s5) <<< 1;
			m_s6[4] <= ww_s5 - xx_s5 + yy_s5 - zz_s5;
			m_s6[5] <= (yz_s5 - wx_s5) <<< 1;
			m_s6[6] <= (xz_s5 - wy_s5) <<< 1;
			m_s6[7] <= (wx_s5 + yz_s5) <<< 1;
			m_s6[8] <= ww_s5 - xx_s5 - yy_s5 + zz_s5;
		end
	end

	// entry division setup with half-divisor rounding bias
	always_comb begin
		logic [46:0] mag;
		ra_c[0].vld   = vld_s6;
		ra_c[0].ident = zero_s6 || n_s6[47] || (n_s6 == 48'sd0);
		ra_c[0].n     = n_s6[46:0];
		for (int k = 0; k < 9; k++) begin
			mag            = m_s6[k][47] ? 47'(-m_s6[k]) : m_s6[k][46:0];
			ra_c[0].neg[k] = m_s6[k][47];
			ra_c[0].rem[k] = ({16'b0, mag} << 14) + {17'b0, n_s6[46:1]};
			ra_c[0].quo[k] = '0;
		end
	end

	for (genvar j = 0; j < RATIO_CELLS; j++) begin : g_ratio
		aar_ratio_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.bpos  (4'(RATIO_CELLS - 1 - j)),
			.d_in  (ra_c[j]),
			.d_out (ra_c[j+1])
		);
	end

	// saturate, apply sign, identity for degenerate input
	always_comb begin
		logic [15:0] mag16;
		for (int k = 0; k < 9; k++) begin
			mag16 = (ra_c[RATIO_CELLS].quo[k] > 15'd16384) ? ONE_Q14 :
				{1'b0, ra_c[RATIO_CELLS].quo[k]};
			if (ra_c[RATIO_CELLS].ident) begin
				r_n[k] = (k == 0 || k == 4 || k == 8) ? ONE_Q14 : 16'd0;
			end else if (ra_c[RATIO_CELLS].neg[k]) begin
				r_n[k] = 16'(16'd0 - mag16);
			end else begin
				r_n[k] = mag16;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ra_c[RATIO_CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r_n;
		end
	end

	assign out_valid = out_vld_q;
	assign r00 = $signed(r_q[0]);
	assign r01 = $signed(r_q[1]);
	assign r02 = $signed(r_q[2]);
	assign r10 = $signed(r_q[3]);
	assign r11 = $signed(r_q[4]);
	assign r12 = $signed(r_q[5]);
	assign r20 = $signed(r_q[6]);
	assign r21 = $signed(r_q[7]);
	assign r22 = $signed(r_q[8]);

	// checks
	`AAR_ASSERT_NOW(a_hold_upstream, !(out_valid && out_stall) || in_stall, "input taken while result held")
	`AAR_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_s1, "accepted beat lost at entry")
	`AAR_ASSERT_NOW(a_diag_range, !out_valid || (r00 <= 16'sd16384 && r00 >= -16'sd16384 && r11 <= 16'sd16384 && r11 >= -16'sd16384 && r22 <= 16'sd16384 && r22 >= -16'sd16384), "diagonal out of range")

endmodule

/* tb/tb_axis_angle_to_rotation_matrix_top.sv */
`timescale 1ns / 100ps
// self-checking bench for the axis-angle to rotation matrix pipeline
// depends on the rtl top level only; predicts each matrix in integer math
module tb_axis_angle_to_rotation_matrix_top;

	localparam int N_RANDOM = 830;
	localparam int TAIL_QUIET = 150;
	localparam int DRAIN_CYCLES = 120;
	localparam int CORDIC_ITERS = 16;

	localparam longint PI_Q28 = 64'sd843314857;
	localparam longint HALF_PI_Q28 = 64'sd421657428;
	localparam longint TWO_PI_Q28 = 64'sd1686629713;
	localparam longint GAIN_Q28 = 64'sd163008218;
	localparam longint UNIT_Q14 = 64'sd16384;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
	} axis_angle_t;

	typedef logic signed [8:0][15:0] matrix_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	axis_angle_t pending_vecs[$];
	matrix_t expected_mats[$];
	int n_errors;
	int n_sent;
	int n_checked;
	bit quiet_mode;
	int src_gap;
	int sink_gap;
	logic accepted_in;

	axis_angle_to_rotation_matrix_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
		.r12(r12), .r20(r20), .r21(r21), .r22(r22)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// floor division by a power of two
	function automatic longint floor_pow2(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(input longint n);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint atan_step(input int i);
		longint tbl[29] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
			32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
			8, 4, 2, 1};
		return (i < 29) ? tbl[i] : 0;
	endfunction

	// m / n in q14, rounded half away from zero, saturated
	function automatic logic signed [15:0] entry_q14(input longint m, input longint n);
		longint mag;
		longint q;
		mag = (m < 0) ? -m : m;
		q = ((mag <<< 14) + n / 2) / n;
		if (q > UNIT_Q14) q = UNIT_Q14;
		return 16'((m < 0) ? -q : q);
	endfunction

	function automatic matrix_t identity_mat();
		matrix_t m;
		m = '0;
		m[0] = 16'sd16384;
		m[4] = 16'sd16384;
		m[8] = 16'sd16384;
		return m;
	endfunction

	// full rotation matrix prediction for one vector
	function automatic matrix_t rotation_of(input axis_angle_t a);
		longint v[3], u[3], q[3], num[9];
		longint sumsq, ang, h, cx, cy, cz, dx, dy, w, n, t;
		bit flip;
		matrix_t m;
		v[0] = a.vx;
		v[1] = a.vy;
		v[2] = a.vz;
		sumsq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
		if (sumsq == 0) return identity_mat();
		ang = int_sqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			t = (((v[i] < 0) ? -v[i] : v[i]) <<< 14) / ang;
			u[i] = (v[i] < 0) ? -t : t;
		end
		// range reduction of the half angle
		flip = 1'b0;
		h = ang <<< 15;
		if (h > PI_Q28) h = h - TWO_PI_Q28;
		if (h > HALF_PI_Q28) begin
			h = h - PI_Q28;
			flip = 1'b1;
		end else if (h < -HALF_PI_Q28) begin
			h = h + PI_Q28;
			flip = 1'b1;
		end
		cx = GAIN_Q28;
		cy = 0;
		cz = h;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = floor_pow2(cy, i);
			dy = floor_pow2(cx, i);
			if (cz >= 0) begin
				cx = cx - dx;
				cy = cy + dy;
				cz = cz - atan_step(i);
			end else begin
				cx = cx + dx;
				cy = cy - dy;
				cz = cz + atan_step(i);
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		w = floor_pow2(cx, 8);
		for (int i = 0; i < 3; i++) q[i] = floor_pow2(floor_pow2(cy * u[i], 14), 8);
		n = w * w + q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
		if (n <= 0) return identity_mat();
		num[0] = w * w + q[0] * q[0] - q[1] * q[1] - q[2] * q[2];
		num[1] = 2 * (q[0] * q[1] - w * q[2]);
		num[2] = 2 * (w * q[1] + q[0] * q[2]);
		num[3] = 2 * (w * q[2] + q[0] * q[1]);
		num[4] = w * w - q[0] * q[0] + q[1] * q[1] - q[2] * q[2];
		num[5] = 2 * (q[1] * q[2] - w * q[0]);
		num[6] = 2 * (q[0] * q[2] - w * q[1]);
		num[7] = 2 * (w * q[0] + q[1] * q[2]);
		num[8] = w * w - q[0] * q[0] - q[1] * q[1] + q[2] * q[2];
		for (int k = 0; k < 9; k++) m[k] = entry_q14(num[k], n);
		return m;
	endfunction

	task automatic report_mismatch(input string what, input int idx,
		input logic signed [15:0] got, input logic signed [15:0] want);
		n_errors++;
		$display("MISMATCH %s beat %0d: got %0d expected %0d", what, idx, got, want);
	endtask

	function automatic axis_angle_t vec3(input int x, input int y, input int z);
		axis_angle_t a;
		a.vx = 16'(x);
		a.vy = 16'(y);
		a.vz = 16'(z);
		return a;
	endfunction

	// append one vector to the stimulus queue
	task automatic add_vec(input axis_angle_t a);
		pending_vecs.insert(pending_vecs.size(), a);
	endtask

	function automatic logic signed [15:0] rand_comp(input int span);
		int r;
		r = $urandom_range(span * 2, 0);
		return 16'(r - span);
	endfunction

	// stimulus: directed corners, then random vectors of mixed magnitude
	initial begin
		int sel;
		int span;
		add_vec(vec3(0, 0, 0));
		add_vec(vec3(32767, 0, 0));
		add_vec(vec3(-32768, 0, 0));
		add_vec(vec3(0, 32767, 0));
		add_vec(vec3(0, -32768, 0));
		add_vec(vec3(0, 0, 32767));
		add_vec(vec3(0, 0, -32768));
		add_vec(vec3(32767, 32767, 32767));
		add_vec(vec3(-32768, -32768, -32768));
		add_vec(vec3(1, 0, 0));
		add_vec(vec3(-1, -1, 1));
		add_vec(vec3(6434, 0, 0));
		add_vec(vec3(0, 12868, 0));
		add_vec(vec3(0, 0, -12868));
		add_vec(vec3(25736, 0, 0));
		add_vec(vec3(12869, 0, 0));
		add_vec(vec3(-6434, 6434, 0));
		add_vec(vec3(16384, -16384, 16384));
		add_vec(vec3(-21846, 10923, 5461));
		add_vec(vec3(21845, -10922, -5462));
		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(3, 0);
			span = (sel == 0) ? 64 : (sel == 1) ? 4096 : (sel == 2) ? 16384 : 32767;
			if ($urandom_range(9, 0) == 0) begin
				add_vec(vec3(rand_comp(span), 0, 0));
			end else begin
				add_vec(vec3(rand_comp(span), rand_comp(span), rand_comp(span)));
			end
			if (sel == 3 && $urandom_range(3, 0) == 0) pending_vecs[$].vz = -32768;
		end
	end

	// source: present the head of the queue, bursty gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			angle_x <= '0;
			angle_y <= '0;
			angle_z <= '0;
			src_gap <= 0;
		end else begin
			if (!in_valid || accepted_in) begin
				if (src_gap > 0) begin
					in_valid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_vecs.size() > 0 &&
					(quiet_mode || $urandom_range(5, 0) != 0)) begin
					in_valid <= 1'b1;
					angle_x <= pending_vecs[0].vx;
					angle_y <= pending_vecs[0].vy;
					angle_z <= pending_vecs[0].vz;
					expected_mats.insert(expected_mats.size(),
						rotation_of(pending_vecs[0]));
					void'(pending_vecs.pop_front());
				end else begin
					in_valid <= 1'b0;
					if (!quiet_mode && pending_vecs.size() > 0)
						src_gap <= $urandom_range(7, 0);
				end
			end
		end
	end

	// acceptance flag sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_in <= 1'b0;
			n_sent <= 0;
		end else begin
			accepted_in <= in_valid && !in_stall;
			if (in_valid && !in_stall) n_sent <= n_sent + 1;
		end
	end

	// sink stall in bursts
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_gap <= 0;
		end else if (quiet_mode) begin
			out_stall <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
		end else if ($urandom_range(5, 0) == 0) begin
			out_stall <= 1'b1;
			sink_gap <= $urandom_range(7, 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: compare each result beat against the oldest prediction
	always @(posedge clk) begin
		matrix_t got;
		matrix_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
			if (expected_mats.size() == 0) begin
				report_mismatch("unexpected r00", n_checked, got[0], 16'sd0);
			end else begin
				want = expected_mats.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want[k])
						report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), n_checked,
							got[k], want[k]);
			end
			n_checked++;
		end
	end

	// reset, quiet tail and end of run
	initial begin
		arst_n = 1'b0;
		n_errors = 0;
		n_checked = 0;
		quiet_mode = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_vecs.size() <= TAIL_QUIET);
		quiet_mode = 1'b1;
		wait (pending_vecs.size() == 0 && !in_valid);
		wait (expected_mats.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d vectors: zero, axis-aligned extremes, wrap angles, random",
			n_sent);
		$display("result beats checked: %0d", n_checked);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("timeout with %0d results outstanding", expected_mats.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
